// ===== rtl/core/sme_pkg.sv =====
`timescale 1ns / 1ps

package sme_pkg;

  localparam int VAL_W = 31;
  localparam int LIM_W = 30;
  localparam int CMD_W = 4;
  localparam int CNT_W = $clog2(VAL_W);

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1000000000);

  localparam logic [CMD_W-1:0] CMD_START = 4'd0;
  localparam logic [CMD_W-1:0] CMD_NUM   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_INV   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DUP   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SWP   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ADD   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SUB   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MUL   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DIV   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_MOD   = 4'd10;
  localparam logic [CMD_W-1:0] CMD_END   = 4'd11;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
    logic [VAL_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/core/stack_machine_evaluator.sv =====
`timescale 1ns / 1ps
// Channel    Handshake                    Payload
// item       item_valid / item_stall      cmd, operand
// result     result_valid / result_stall  result_value, run_error
// config     psel, penable, pwrite        paddr, pwdata, prdata, pready
//
// START, NUM, INV, DUP, END, unused codes, ignored and underflowing commands
// stay in S_IDLE; POP goes via S_POP; SWP, ADD, SUB and a zero divisor via S_FETCH;
// MUL adds S_MCHK; DIV, MOD wait in S_DIV on the shared one-bit-per-cycle divider.
// The top entry lives in a register, the rest in a 1-read 1-write memory.
// Reset is synchronous, clears state, depth, error, result valid and presets limit.
// Only END waits while an earlier result is still stalled.

module stack_machine_evaluator import sme_pkg::*; #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [CMD_W-1:0]        cmd,
  input  logic signed [VAL_W-1:0] operand,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [VAL_W-1:0] result_value,
  output logic                    run_error,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [0:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_MCHK  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  logic [2:0]              state;
  logic [DW-1:0]           depth;
  logic                    err;
  logic signed [VAL_W-1:0] tos;
  logic [CMD_W-1:0]        op;
  logic [LIM_W-1:0]        limit;
  logic signed [61:0]      prod;
  logic                    a_neg;
  logic                    b_neg;
  logic                    res_valid;

  logic [VAL_W-1:0]        stack_mem [STACK_DEPTH];
  logic [VAL_W-1:0]        rd_data;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [AW-1:0]           mem_raddr;

  logic                    accept;
  logic                    cfg_wr;
  logic [DW-1:0]           depth_m1;
  logic [DW-1:0]           depth_m2;
  logic                    has1;
  logic                    has2;
  logic                    full;

  logic signed [VAL_W-1:0] a_s;
  logic signed [32:0]      sum;
  logic signed [32:0]      dif;
  logic signed [32:0]      lim33;
  logic                    sum_over;
  logic                    dif_over;
  logic signed [61:0]      mul_p;
  logic signed [61:0]      lim62;
  logic                    prod_over;
  logic [VAL_W-1:0]        a_mag;
  logic [VAL_W-1:0]        b_mag;

  logic                    q_neg;
  logic [VAL_W-1:0]        q_s;
  logic [VAL_W-1:0]        r_s;
  logic                    q_ovf;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);
  assign prdata = (paddr == 1'b0) ? {{(32-LIM_W){1'b0}}, limit} : 32'd0;

  assign item_stall   = (state != S_IDLE) || (res_valid && result_stall && cmd == CMD_END);
  assign accept       = item_valid && !item_stall;
  assign result_valid = res_valid;

  assign depth_m1 = depth - 1'b1;
  assign depth_m2 = depth - DW'(2);
  assign has1     = depth != '0;
  assign has2     = depth > DW'(1);
  assign full     = depth == DW'(STACK_DEPTH);

  assign a_s   = $signed(rd_data);
  assign sum   = {{2{a_s[VAL_W-1]}}, a_s} + {{2{tos[VAL_W-1]}}, tos};
  assign dif   = {{2{a_s[VAL_W-1]}}, a_s} - {{2{tos[VAL_W-1]}}, tos};
  assign lim33 = $signed({3'b000, limit});
  assign sum_over = (sum > lim33) || (sum < -lim33);
  assign dif_over = (dif > lim33) || (dif < -lim33);

  assign mul_p = a_s * tos;
  assign lim62 = $signed({32'd0, limit});
  assign prod_over = (prod > lim62) || (prod < -lim62);

  assign a_mag = rd_data[VAL_W-1] ? (~rd_data + 1'b1) : rd_data;
  assign b_mag = tos[VAL_W-1] ? (~tos + 1'b1) : tos;

  assign q_neg = a_neg ^ b_neg;
  assign q_s   = q_neg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
  assign q_ovf = !q_neg && div_rsp.quotient[VAL_W-1];
  assign r_s   = a_neg ? (~div_rsp.remainder + 1'b1) : div_rsp.remainder;

  assign div_req.start    = (state == S_FETCH) && (op == CMD_DIV || op == CMD_MOD)
                            && (tos != '0);
  assign div_req.dividend = a_mag;
  assign div_req.divisor  = b_mag;

  sme_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = depth_m1[AW-1:0];
    if (state == S_IDLE && accept && !err && has1 && !full
        && (cmd == CMD_NUM || cmd == CMD_DUP)) begin
      mem_we = 1'b1;
    end else if (state == S_FETCH && op == CMD_SWP) begin
      mem_we    = 1'b1;
      mem_waddr = depth_m2[AW-1:0];
    end
  end

  assign mem_raddr = depth_m2[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= tos;
    end
    if (state == S_IDLE) begin
      rd_data <= stack_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      err       <= 1'b0;
      limit     <= LIMIT_RESET;
      res_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        limit <= pwdata[LIM_W-1:0];
      end
      if (res_valid && !result_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= cmd;
            if (cmd == CMD_START) begin
              tos   <= operand;
              depth <= DW'(1);
              err   <= 1'b0;
            end else if (cmd == CMD_END) begin
              res_valid <= 1'b1;
              if (err || depth != DW'(1)) begin
                run_error    <= 1'b1;
                result_value <= '0;
              end else begin
                run_error    <= 1'b0;
                result_value <= tos;
              end
            end else if (!err) begin
              case (cmd)
                CMD_NUM: begin
                  if (full) begin
                    err <= 1'b1;
                  end else begin
                    tos   <= operand;
                    depth <= depth + 1'b1;
                  end
                end
                CMD_POP: begin
                  if (!has1) begin
                    err <= 1'b1;
                  end else begin
                    depth <= depth_m1;
                    state <= S_POP;
                  end
                end
                CMD_INV: begin
                  if (!has1 || tos == {1'b1, {(VAL_W-1){1'b0}}}) begin
                    err <= 1'b1;
                  end else begin
                    tos <= -tos;
                  end
                end
                CMD_DUP: begin
                  if (!has1 || full) begin
                    err <= 1'b1;
                  end else begin
                    depth <= depth + 1'b1;
                  end
                end
                CMD_SWP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                  if (!has2) begin
                    err <= 1'b1;
                  end else begin
                    state <= S_FETCH;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_POP: begin
          tos   <= a_s;
          state <= S_IDLE;
        end
        S_FETCH: begin
          a_neg <= rd_data[VAL_W-1];
          b_neg <= tos[VAL_W-1];
          state <= S_IDLE;
          case (op)
            CMD_SWP: begin
              tos <= a_s;
            end
            CMD_ADD: begin
              if (sum_over) begin
                err <= 1'b1;
              end else begin
                tos   <= sum[VAL_W-1:0];
                depth <= depth_m1;
              end
            end
            CMD_SUB: begin
              if (dif_over) begin
                err <= 1'b1;
              end else begin
                tos   <= dif[VAL_W-1:0];
                depth <= depth_m1;
              end
            end
            CMD_MUL: begin
              prod  <= mul_p;
              state <= S_MCHK;
            end
            CMD_DIV, CMD_MOD: begin
              if (tos == '0) begin
                err <= 1'b1;
              end else begin
                state <= S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
        S_MCHK: begin
          if (prod_over) begin
            err <= 1'b1;
          end else begin
            tos   <= prod[VAL_W-1:0];
            depth <= depth_m1;
          end
          state <= S_IDLE;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_IDLE;
            if (op == CMD_DIV) begin
              if (q_ovf) begin
                err <= 1'b1;
              end else begin
                tos   <= $signed(q_s);
                depth <= depth_m1;
              end
            end else begin
              tos   <= $signed(r_s);
              depth <= depth_m1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sme_div.sv =====
`timescale 1ns / 1ps

module sme_div import sme_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(VAL_W - 1);

  logic [VAL_W-1:0] quo;
  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;

  logic [VAL_W-1:0] shifted;
  logic [VAL_W:0]   trial;

  assign shifted = {rem[VAL_W-2:0], quo[VAL_W-1]};
  assign trial   = {1'b0, shifted} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[VAL_W]) begin
        rem <= trial[VAL_W-1:0];
        quo <= {quo[VAL_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[VAL_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
